### hdl/htab_pkg.sv
// shared types, codes and constants for the handle table
`timescale 1ns / 1ps
`default_nettype none
package htab_pkg;

  localparam int TABLE_SLOTS_DEF = 16;
  localparam int RESERVED_SLOTS  = 3;
  localparam int CHUNK_W         = 16;
  localparam int CHUNK_IW        = 4;

  localparam logic [2:0] MODE_OPEN   = 3'd0;
  localparam logic [2:0] MODE_CLOSE  = 3'd1;
  localparam logic [2:0] MODE_LOOKUP = 3'd2;
  localparam logic [2:0] MODE_ADD    = 3'd3;
  localparam logic [2:0] MODE_REMOVE = 3'd4;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  localparam logic signed [16:0] HANDLE_NONE = -17'sd1;
  localparam logic [7:0]         SHARERS_MAX = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_hit;
    logic scan_last;
  } dp_status_t;

endpackage
`default_nettype wire

### hdl/htab_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module htab_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/htab_ctrl.sv
// controller state machine for the handle table
`timescale 1ns / 1ps
`default_nettype none
module htab_ctrl
  import htab_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  input  wire logic [2:0] mode,
  input  wire logic       rsp_ready,
  input  wire dp_status_t dp_status,
  output logic            req_ready,
  output logic            rsp_valid,
  output dp_cmd_t         dp_cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          dp_cmd.load = 1'b1;
          case (mode)
            MODE_OPEN:                state_next = ST_SCAN;
            MODE_CLOSE, MODE_LOOKUP:  state_next = ST_READ;
            default:                  state_next = ST_FIN;
          endcase
        end
      end
      ST_SCAN: begin
        dp_cmd.scan = 1'b1;
        if (dp_status.scan_hit || dp_status.scan_last) begin
          state_next = ST_FIN;
        end
      end
      ST_READ: begin
        // wait for the registered handle read
        state_next = ST_FIN;
      end
      ST_FIN: begin
        dp_cmd.commit = 1'b1;
        state_next    = ST_OUT;
      end
      ST_OUT: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### hdl/htab_dp.sv
// datapath: used map, free-slot scan, handle ram, sharer count, result registers
`timescale 1ns / 1ps
`default_nettype none
module htab_dp
  import htab_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dp_cmd_t           dp_cmd,
  input  wire logic [2:0]        mode,
  input  wire logic [7:0]        slot_index,
  input  wire logic [15:0]       host_handle,
  output dp_status_t             dp_status,
  output logic [1:0]             status,
  output logic [7:0]             assigned_slot,
  output logic signed [16:0]     held_handle,
  output logic                   slot_open,
  output logic [7:0]             sharer_count
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int NCHUNK = (TABLE_SLOTS + CHUNK_W - 1) / CHUNK_W;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PAD_W  = NCHUNK * CHUNK_W;

  // latched request word
  logic [2:0]  mode_r;
  logic [7:0]  idx_r;
  logic [15:0] host_r;

  logic [TABLE_SLOTS-1:0]    used;
  logic [RESERVED_SLOTS-1:0] fresh;
  logic [7:0]                sharers;

  logic [CW-1:0]     chunk;
  logic [SLOT_W-1:0] free_slot;
  logic              full;

  logic [PAD_W-1:0]    used_pad;
  logic [CHUNK_W-1:0]  chunk_bits;
  logic [CHUNK_IW-1:0] enc;
  logic                hit;
  logic [SLOT_W-1:0]   found_slot;

  logic [SLOT_W-1:0] idx_s;
  logic              in_range;
  logic              slot_ok;
  logic              fresh_hit;
  logic [15:0]       ram_rdata;
  logic signed [16:0] stored_handle;
  logic              ram_we;

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      mode_r <= mode;
      idx_r  <= slot_index;
      host_r <= host_handle;
    end
  end

  // free-slot scan, one chunk of the used map per cycle
  always_comb begin
    used_pad = {PAD_W{1'b1}};
    used_pad[TABLE_SLOTS-1:0] = used;
  end

  assign chunk_bits = used_pad[chunk*CHUNK_W +: CHUNK_W];

  always_comb begin
    enc = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (!chunk_bits[i]) begin
        enc = CHUNK_IW'(i);
      end
    end
  end

  assign hit        = ~&chunk_bits;
  assign found_slot = SLOT_W'({chunk, enc});

  assign dp_status.scan_hit  = hit;
  assign dp_status.scan_last = (chunk == CW'(NCHUNK - 1));

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      chunk <= '0;
    end else if (dp_cmd.scan) begin
      if (hit) begin
        free_slot <= found_slot;
        full      <= 1'b0;
      end else if (dp_status.scan_last) begin
        full <= 1'b1;
      end else begin
        chunk <= chunk + 1'b1;
      end
    end
  end

  // slot checks for close and lookup
  assign idx_s     = idx_r[SLOT_W-1:0];
  assign in_range  = ({1'b0, idx_r} < 9'(TABLE_SLOTS));
  assign slot_ok   = in_range && used[idx_s];
  assign fresh_hit = (idx_r < 8'(RESERVED_SLOTS)) && fresh[idx_r[$clog2(RESERVED_SLOTS)-1:0]];
  assign stored_handle = fresh_hit ? HANDLE_NONE : $signed({1'b0, ram_rdata});

  assign ram_we = dp_cmd.commit && (mode_r == MODE_OPEN) && !full;

  htab_ram #(
    .WIDTH (16),
    .DEPTH (TABLE_SLOTS)
  ) u_handle_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_slot),
    .wdata (host_r),
    .raddr (idx_s),
    .rdata (ram_rdata)
  );

  // table state
  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= {{(TABLE_SLOTS - RESERVED_SLOTS){1'b0}}, {RESERVED_SLOTS{1'b1}}};
      fresh   <= {RESERVED_SLOTS{1'b1}};
      sharers <= '0;
    end else if (dp_cmd.commit) begin
      case (mode_r)
        MODE_OPEN: begin
          if (!full) begin
            used[free_slot] <= 1'b1;
          end
        end
        MODE_CLOSE: begin
          if (slot_ok) begin
            used[idx_s] <= 1'b0;
            if (idx_r < 8'(RESERVED_SLOTS)) begin
              fresh[idx_r[$clog2(RESERVED_SLOTS)-1:0]] <= 1'b0;
            end
          end
        end
        MODE_ADD: begin
          if (sharers != SHARERS_MAX) begin
            sharers <= sharers + 8'd1;
          end
        end
        MODE_REMOVE: begin
          if (sharers != 8'd0) begin
            sharers <= sharers - 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      status        <= STATUS_OK;
      assigned_slot <= '0;
      held_handle   <= HANDLE_NONE;
      slot_open     <= 1'b0;
      case (mode_r)
        MODE_OPEN: begin
          if (full) begin
            status <= STATUS_FULL;
          end else begin
            assigned_slot <= 8'(free_slot);
          end
        end
        MODE_CLOSE: begin
          if (slot_ok) begin
            held_handle <= stored_handle;
          end else begin
            status <= STATUS_BAD;
          end
        end
        MODE_LOOKUP: begin
          if (slot_ok) begin
            held_handle <= stored_handle;
            slot_open   <= 1'b1;
          end else begin
            status <= STATUS_BAD;
          end
        end
        default: ;
      endcase
    end
  end

  assign sharer_count = sharers;

endmodule
`default_nettype wire

### hdl/handle_table_first_free_alloc.sv
// top level of the handle table with lowest-free-slot allocation
// sequence: open scans the used map one 16-slot chunk at a time up to the chunk that holds
//   the first free slot (all chunks when the table is full); close and lookup wait for the
//   registered handle ram read; sharer modes and unused modes go straight on; each word then
//   commits, and rsp_valid is held until rsp_ready
// one word in flight at a time; the next request is accepted only after the response is taken
// reset: slots 0 to 2 open holding no handle, all others free, sharer count zero;
//   ready as soon as reset is released, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module handle_table_first_free_alloc
  import htab_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // request channel
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire logic [2:0]    mode,
  input  wire logic [7:0]    slot_index,
  input  wire logic [15:0]   host_handle,
  // response channel
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output logic [1:0]         status,
  output logic [7:0]         assigned_slot,
  output logic signed [16:0] held_handle,
  output logic               slot_open,
  output logic [7:0]         sharer_count
);

  // command and status between the sequencer and the datapath
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // sequencer: idle, chunked free-slot scan, ram read wait, commit, response hold
  htab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .mode      (mode),
    .rsp_ready (rsp_ready),
    .dp_status (dp_status),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .dp_cmd    (dp_cmd)
  );

  // datapath: used map in flops, handles in ram, result registers held until taken
  htab_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .dp_cmd        (dp_cmd),
    .mode          (mode),
    .slot_index    (slot_index),
    .host_handle   (host_handle),
    .dp_status     (dp_status),
    .status        (status),
    .assigned_slot (assigned_slot),
    .held_handle   (held_handle),
    .slot_open     (slot_open),
    .sharer_count  (sharer_count)
  );

endmodule
`default_nettype wire
